// ----- sv/gbs_pkg.sv -----
`default_nettype none
package gbs_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_SHIFT,
    ST_WRITE,
    ST_OUTER,
    ST_INNER_RD,
    ST_INNER_EV,
    ST_EMIT_RD,
    ST_EMIT,
    ST_EMPTY
  } gbs_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;     // latch the incoming word
    logic       scan_clr;    // reset scan pointer to zero
    logic       scan_inc;    // advance scan pointer
    logic       mem_rd;      // read store at scan pointer
    logic       shift_wr;    // move entry k-1 to k
    logic       shift_dec;   // step shift pointer down
    logic       shift_init;  // shift pointer = top slot
    logic       ins_wr;      // write new word at insert slot
    logic       ins_count;   // commit count/overflow after insert
    logic       outer_init;  // outer = 0
    logic       outer_inc;   // outer++
    logic       outer_rd;    // read store at outer pointer
    logic       outer_hold;  // latch outer entry
    logic       inner_init;  // inner = outer+1
    logic       inner_inc;   // inner++
    logic       inner_rd;    // read store at inner pointer
    logic       eval;        // apply overlap result to marks
    logic       emit_rd;     // read store at emit pointer
    logic       emit;        // present one result
    logic       emit_inc;    // advance emit pointer
    logic       empty_out;   // empty set result
    logic       clear_run;   // drop count, marks and overflow
  } gbs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic find_done;    // scan reached insert slot
    logic drop_new;     // full store and new word falls off the end
    logic shift_done;   // shift pointer at insert slot
    logic count_zero;   // store empty
    logic outer_done;   // outer pointer past count
    logic outer_marked; // outer entry suppressed
    logic inner_done;   // inner pointer past count
    logic emit_done;    // emit pointer past count
    logic emit_marked;  // entry at emit pointer suppressed
    logic emit_last;    // no kept entry after emit pointer
  } gbs_stat_t;

endpackage
`default_nettype wire

// ----- sv/greedy_box_suppression.sv -----
`default_nettype none
// Greedy box suppression by overlap ratio.
// Boxes arrive one word per start pulse (start high while busy low). Each
// box is placed into a score-ordered store: a scan reads one entry a cycle
// to find the slot, then entries move down one a cycle.
// The word with set_end starts the suppression pass: each kept entry is
// compared with every later one, then every entry is visited and
// survivors are shown on the result ports for a single cycle each, marked
// by result_valid_o; final_result marks the last.
// An empty set gives one word with none_kept.
// The receiver cannot stall.
// The user must write the overlap limit through cfg_valid_i/cfg_ready_o while
// idle; the block does not enforce this. Reset clears count, marks and
// overflow and sets the limit to 0.45; the store contents need no clearing.
module greedy_box_suppression #(
  parameter int MAX_BOXES = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] box_left_i,
  input  wire logic signed [15:0] box_top_i,
  input  wire logic signed [15:0] box_right_i,
  input  wire logic signed [15:0] box_bottom_i,
  input  wire logic [15:0]        box_score_i,
  input  wire logic [6:0]         box_class_i,
  input  wire logic               box_present_i,
  input  wire logic               set_end_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [15:0]        cfg_data_i,
  output logic                    result_valid_o,
  output logic signed [15:0]      out_left_o,
  output logic signed [15:0]      out_top_o,
  output logic signed [15:0]      out_right_o,
  output logic signed [15:0]      out_bottom_o,
  output logic [15:0]             out_score_o,
  output logic [6:0]              out_class_o,
  output logic                    none_kept_o,
  output logic                    overflowed_o,
  output logic                    final_result_o
);
  import gbs_pkg::*;

  gbs_cmd_t  cmd;
  gbs_stat_t stat;

  assign cfg_ready_o = 1'b1;

  gbs_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .box_present_i, .set_end_i,
    .stat_i (stat), .cmd_o (cmd), .busy
  );

  gbs_dp #(.MaxBoxes(MAX_BOXES)) u_dp (
    .clk_i, .rst_ni, .cmd_i (cmd), .stat_o (stat),
    .cfg_valid_i, .cfg_data_i,
    .box_left_i, .box_top_i, .box_right_i, .box_bottom_i, .box_score_i, .box_class_i,
    .result_valid_o, .out_left_o, .out_top_o, .out_right_o, .out_bottom_o,
    .out_score_o, .out_class_o, .none_kept_o, .overflowed_o, .final_result_o
  );

`ifndef ASSERT_OFF
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy)) else $error("result outside run");
  a_none_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && none_kept_o) |-> final_result_o) else $error("empty not final");
  a_final_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && final_result_o && !none_kept_o) |=> ##1 !result_valid_o)
    else $error("result after final");
`endif

endmodule
`default_nettype wire

// ----- sv/gbs_ram.sv -----
`default_nettype none
module gbs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write one port, read one port, read data registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- sv/gbs_ctrl.sv -----
`default_nettype none
module gbs_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire logic               box_present_i,
  input  wire logic               set_end_i,
  input  wire gbs_pkg::gbs_stat_t stat_i,
  output gbs_pkg::gbs_cmd_t       cmd_o,
  output logic                    busy
);
  import gbs_pkg::*;

  gbs_state_e state_q, state_d;
  logic       end_q, end_d;

  // Hold state and the end marker of the current word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      end_q   <= end_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    end_d   = end_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          end_d = set_end_i;
          if (box_present_i) state_d = ST_FIND;
          else if (set_end_i) state_d = ST_OUTER;
        end
      end
      ST_FIND: begin
        if (stat_i.find_done) begin
          if (stat_i.drop_new) state_d = end_q ? ST_OUTER : ST_IDLE;
          else state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: if (stat_i.shift_done) state_d = ST_WRITE;
      ST_WRITE: state_d = end_q ? ST_OUTER : ST_IDLE;
      ST_OUTER: begin
        if (stat_i.count_zero) state_d = ST_EMPTY;
        else if (stat_i.outer_done) state_d = ST_EMIT_RD;
        else state_d = ST_INNER_RD;
      end
      ST_INNER_RD: begin
        if (stat_i.outer_marked || stat_i.inner_done) state_d = ST_OUTER;
        else state_d = ST_INNER_EV;
      end
      ST_INNER_EV: state_d = ST_INNER_RD;
      ST_EMIT_RD: begin
        if (stat_i.emit_done) state_d = ST_IDLE;
        else state_d = ST_EMIT;
      end
      ST_EMIT:  state_d = ST_EMIT_RD;
      ST_EMPTY: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.capture  = 1'b1;
          cmd_o.scan_clr = 1'b1;
          cmd_o.mem_rd   = 1'b1;
          cmd_o.outer_init = 1'b1;
        end
      end
      ST_FIND: begin
        if (!stat_i.find_done) begin
          cmd_o.scan_inc = 1'b1;
          cmd_o.mem_rd   = 1'b1;
        end else if (stat_i.drop_new) begin
          cmd_o.ins_count = 1'b1;
        end else begin
          cmd_o.shift_init = 1'b1;
        end
      end
      ST_SHIFT: begin
        if (!stat_i.shift_done) begin
          cmd_o.shift_wr  = 1'b1;
          cmd_o.shift_dec = 1'b1;
        end
      end
      ST_WRITE: begin
        cmd_o.ins_wr    = 1'b1;
        cmd_o.ins_count = 1'b1;
      end
      ST_OUTER: begin
        cmd_o.outer_rd   = 1'b1;
        cmd_o.inner_init = 1'b1;
      end
      ST_INNER_RD: begin
        if (stat_i.inner_done && !stat_i.outer_marked) begin
          cmd_o.outer_inc = 1'b1;
        end else if (stat_i.outer_marked) begin
          cmd_o.outer_inc = 1'b1;
        end else begin
          cmd_o.inner_rd = 1'b1;
        end
        cmd_o.outer_hold = 1'b1;
      end
      ST_INNER_EV: begin
        cmd_o.eval      = 1'b1;
        cmd_o.inner_inc = 1'b1;
        cmd_o.outer_rd  = 1'b1;
      end
      ST_EMIT_RD: begin
        if (stat_i.emit_done) cmd_o.clear_run = 1'b1;
        else cmd_o.emit_rd = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit     = ~stat_i.emit_marked;
        cmd_o.emit_inc = 1'b1;
      end
      ST_EMPTY: begin
        cmd_o.empty_out = 1'b1;
        cmd_o.clear_run = 1'b1;
      end
      default: ;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule
`default_nettype wire

// ----- sv/gbs_dp.sv -----
`default_nettype none
module gbs_dp #(
  parameter int MaxBoxes = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire gbs_pkg::gbs_cmd_t  cmd_i,
  output gbs_pkg::gbs_stat_t      stat_o,
  input  wire logic               cfg_valid_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic signed [15:0] box_left_i,
  input  wire logic signed [15:0] box_top_i,
  input  wire logic signed [15:0] box_right_i,
  input  wire logic signed [15:0] box_bottom_i,
  input  wire logic [15:0]        box_score_i,
  input  wire logic [6:0]         box_class_i,
  output logic                    result_valid_o,
  output logic signed [15:0]      out_left_o,
  output logic signed [15:0]      out_top_o,
  output logic signed [15:0]      out_right_o,
  output logic signed [15:0]      out_bottom_o,
  output logic [15:0]             out_score_o,
  output logic [6:0]              out_class_o,
  output logic                    none_kept_o,
  output logic                    overflowed_o,
  output logic                    final_result_o
);
  import gbs_pkg::*;

  localparam int AW = $clog2(MaxBoxes);
  localparam int CW = $clog2(MaxBoxes + 1);
  localparam int EW = 87;  // corners, score, class
  localparam logic [CW-1:0] Full = CW'(MaxBoxes);

  logic [15:0]   limit_q;
  logic [EW-1:0] new_q;
  logic [CW-1:0] count_q, scan_q, shp_q, outer_q, inner_q, emit_q;
  logic          ovf_q;
  logic [MaxBoxes-1:0] mark_q;
  logic [EW-1:0] rdata;
  logic [EW-1:0] hold_q;
  logic          scan_vld_q;
  logic          eval_q;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= 16'd29491;
    else if (cfg_valid_i) limit_q <= cfg_data_i;
  end

  // Store read and write addresses.
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;
  logic [CW-1:0] shp_m1;
  assign shp_m1 = shp_q - 1'b1;

  always_comb begin
    we    = cmd_i.shift_wr | cmd_i.ins_wr;
    waddr = cmd_i.ins_wr ? scan_q[AW-1:0] : shp_q[AW-1:0];
    wdata = cmd_i.ins_wr ? new_q : rdata;
    raddr = scan_q[AW-1:0];
    if (cmd_i.scan_clr) raddr = '0;
    else if (cmd_i.scan_inc) raddr = AW'(scan_q + 1'b1);
    else if (cmd_i.shift_init) raddr = AW'(((count_q == Full) ? Full - 1'b1 : count_q) - 1'b1);
    else if (cmd_i.shift_wr) raddr = AW'(shp_m1 - 1'b1);
    else if (cmd_i.outer_rd) raddr = cmd_i.eval ? AW'(inner_q + 1'b1) : outer_q[AW-1:0];
    else if (cmd_i.inner_rd) raddr = inner_q[AW-1:0];
    else if (cmd_i.emit_rd) raddr = emit_q[AW-1:0];
  end

  gbs_ram #(.Width(EW), .Depth(MaxBoxes)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Entry fields.
  logic [15:0] r_score, n_score;
  assign r_score = rdata[22:7];
  assign n_score = new_q[22:7];

  // Scan: the slot is where stored score is below the new one.
  logic at_end;
  assign at_end = (scan_q >= count_q);
  assign stat_o.find_done  = scan_vld_q && (at_end || (r_score < n_score));
  assign stat_o.drop_new   = (count_q == Full) && at_end;
  assign stat_o.shift_done = (shp_q == scan_q);
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.outer_done = (outer_q >= count_q);
  assign stat_o.outer_marked = mark_q[outer_q[AW-1:0]];
  assign stat_o.inner_done = (inner_q >= count_q);
  assign stat_o.emit_done  = (emit_q >= count_q);
  assign stat_o.emit_marked = mark_q[emit_q[AW-1:0]];

  // Last kept entry: no unmarked entry above the emit pointer.
  logic [MaxBoxes-1:0] above;
  always_comb begin
    for (int k = 0; k < MaxBoxes; k++) begin
      above[k] = (CW'(k) > emit_q) && (CW'(k) < count_q) && !mark_q[k];
    end
  end
  assign stat_o.emit_last = ~|above;

  // Overlap test: products of the pair are registered in the evaluate cycle,
  // the compare and mark update follow in the next cycle.
  logic signed [16:0] iw, ih, wa, ha, wb, hb;
  logic signed [15:0] al, at, ar, ab, bl, bt, br, bb;
  assign al = hold_q[86:71]; assign at = hold_q[70:55];
  assign ar = hold_q[54:39]; assign ab = hold_q[38:23];
  assign bl = rdata[86:71];  assign bt = rdata[70:55];
  assign br = rdata[54:39];  assign bb = rdata[38:23];
  always_comb begin
    iw = 17'((ar < br) ? ar : br) - 17'((al > bl) ? al : bl);
    ih = 17'((ab < bb) ? ab : bb) - 17'((at > bt) ? at : bt);
    wa = 17'(ar) - 17'(al);
    ha = 17'(ab) - 17'(at);
    wb = 17'(br) - 17'(bl);
    hb = 17'(bb) - 17'(bt);
  end

  // Products registered, union formed from them before the final compare.
  logic signed [34:0] inter_q, area_a_q, area_b_q;
  logic               pos_q;
  logic signed [36:0] uni;
  logic signed [53:0] lhs, rhs;
  logic               hit;
  always_ff @(posedge clk_i) begin
    inter_q  <= 35'(iw * ih);
    area_a_q <= 35'(wa * ha);
    area_b_q <= 35'(wb * hb);
    pos_q    <= (iw > 0) && (ih > 0);
  end
  assign uni = 37'(area_a_q) + 37'(area_b_q) - 37'(inter_q);
  assign lhs = {inter_q[34], inter_q, 18'd0} >>> 2;
  assign rhs = 54'($signed({1'b0, limit_q})) * 54'(uni);
  assign hit = pos_q && (lhs > rhs);

  // Pointers, count, marks and captured word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      ovf_q      <= 1'b0;
      mark_q     <= '0;
      scan_q     <= '0;
      shp_q      <= '0;
      outer_q    <= '0;
      inner_q    <= '0;
      emit_q     <= '0;
      scan_vld_q <= 1'b0;
      eval_q     <= 1'b0;
    end else begin
      scan_vld_q <= cmd_i.mem_rd;
      eval_q     <= cmd_i.eval;
      if (cmd_i.scan_clr) scan_q <= '0;
      else if (cmd_i.scan_inc) scan_q <= scan_q + 1'b1;
      if (cmd_i.shift_init) shp_q <= (count_q == Full) ? Full - 1'b1 : count_q;
      else if (cmd_i.shift_dec) shp_q <= shp_m1;
      if (cmd_i.ins_count) begin
        if (count_q == Full) ovf_q <= 1'b1;
        else count_q <= count_q + 1'b1;
      end
      if (cmd_i.outer_init) begin
        outer_q <= '0;
        emit_q  <= '0;
      end else if (cmd_i.outer_inc) outer_q <= outer_q + 1'b1;
      if (cmd_i.inner_init) inner_q <= outer_q + 1'b1;
      else if (cmd_i.inner_inc) inner_q <= inner_q + 1'b1;
      // Mark the pair's later entry, the inner pointer has moved on by one.
      if (eval_q && hit && !mark_q[inner_q[AW-1:0] - 1'b1])
        mark_q[inner_q[AW-1:0] - 1'b1] <= 1'b1;
      if (cmd_i.emit_inc) emit_q <= emit_q + 1'b1;
      if (cmd_i.clear_run) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
        mark_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      new_q <= {box_left_i, box_top_i, box_right_i, box_bottom_i, box_score_i, box_class_i};
    end
    if (cmd_i.outer_hold && !cmd_i.inner_rd) hold_q <= hold_q;
    else if (cmd_i.outer_hold && inner_q == outer_q + 1'b1) hold_q <= rdata;
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.emit | cmd_i.empty_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.empty_out) begin
      {out_left_o, out_top_o, out_right_o, out_bottom_o} <= '0;
      out_score_o    <= '0;
      out_class_o    <= '0;
      none_kept_o    <= 1'b1;
      overflowed_o   <= ovf_q;
      final_result_o <= 1'b1;
    end else if (cmd_i.emit) begin
      {out_left_o, out_top_o, out_right_o, out_bottom_o} <= rdata[86:23];
      out_score_o    <= rdata[22:7];
      out_class_o    <= rdata[6:0];
      none_kept_o    <= 1'b0;
      overflowed_o   <= ovf_q;
      final_result_o <= stat_o.emit_last;
    end
  end

endmodule
`default_nettype wire
